/* rtl/ddwr_pkg.sv */
// Package for the differential-drive wheel rate block.
// Holds field widths, reset values, register indexes and the shared structs.
// No dependencies.
package ddwr_pkg;

	// Default fraction bits of the fixed-point inputs and registers.
	localparam int FRAC_BITS_DEF = 16;

	// Field widths.
	localparam int DATA_W = 32;
	localparam int LIM_W  = 24;
	localparam int OUT_W  = 25;
	localparam int IDX_W  = 2;

	// Register indexes on the configuration channel.
	localparam logic [IDX_W-1:0] REG_TRACK_WIDTH     = 2'd0;
	localparam logic [IDX_W-1:0] REG_COUNTS_PER_UNIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_ENCODER_LIMIT   = 2'd2;

	// Register reset values.
	localparam logic [DATA_W-1:0] TRACK_WIDTH_RST     = 32'd65536;
	localparam logic [DATA_W-1:0] COUNTS_PER_UNIT_RST = 32'd65536;
	localparam logic [LIM_W-1:0]  ENCODER_LIMIT_RST   = 24'd1000000;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [DATA_W-1:0] track_width;
		logic [DATA_W-1:0] counts_per_unit;
		logic [LIM_W-1:0]  encoder_limit;
	} cfg_t;

	// Control bits that travel with each command down the pipeline.
	typedef struct packed {
		logic valid;
		logic neg_l;
		logic neg_r;
		logic over;
	} ctl_t;

endpackage

/* rtl/ddwr_cfg.sv */
// Configuration register file of the differential-drive wheel rate block.
// Depends on ddwr_pkg for register indexes, reset values and cfg_t.
module ddwr_cfg import ddwr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	// Writes are always taken; an index beyond the list is dropped.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes, one per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_width     <= TRACK_WIDTH_RST;
			cfg_q.counts_per_unit <= COUNTS_PER_UNIT_RST;
			cfg_q.encoder_limit   <= ENCODER_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TRACK_WIDTH:     cfg_q.track_width     <= cfg_data;
				REG_COUNTS_PER_UNIT: cfg_q.counts_per_unit <= cfg_data;
				REG_ENCODER_LIMIT:   cfg_q.encoder_limit   <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/ddwr_kin.sv */
// Kinematics front end: five pipeline stages from a command to the rounded
// wheel magnitudes and signs. Depends on ddwr_pkg for cfg_t and ctl_t.
module ddwr_kin import ddwr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [DATA_W-1:0]  fwd_speed,
	input  logic signed [DATA_W-1:0]  turn_rate,
	input  cfg_t                      cfg,
	output ctl_t                      ctl,
	output logic [96-3*FRAC_BITS-1:0] q_l,
	output logic [96-3*FRAC_BITS-1:0] q_r
);

	// Rounding shift and width of a rounded magnitude.
	localparam int SH  = 3*FRAC_BITS + 1;
	localparam int Q_W = 97 - SH;
	localparam logic [96:0] RND = 97'(1) << (SH - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [31:0] abs_s_s1, abs_r_s1;
	logic        neg_s_s1, neg_r_s1;

	logic [63:0] mag_s_s2, mag_r_s2;
	logic        neg_s_s2, neg_r_s2;

	logic [63:0] mag_l_s3, mag_r_s3;
	logic        neg_l_s3, neg_r_s3;

	logic [63:0] pp_lo_l_s4, pp_hi_l_s4, pp_lo_r_s4, pp_hi_r_s4;
	logic        neg_l_s4, neg_r_s4;

	logic [Q_W-1:0] q_l_s5, q_r_s5;
	logic           neg_l_s5, neg_r_s5;

	logic [63:0] prod_r;
	logic [64:0] mix_l, mix_r;
	logic [96:0] sum_l, sum_r;
	logic [Q_W-1:0] qraw_l, qraw_r, qfix_l, qfix_r;
	logic        nz_l, nz_r;

	// Signed sum of two sign-magnitude values, returned as {sign, magnitude}.
	function automatic logic [64:0] lane_mix(input logic [63:0] ms, input logic ns,
			input logic [63:0] mr, input logic nr);
		logic [64:0] res;
		if (ns == nr) begin
			res = {ns, ms + mr};
		end else if (ms >= mr) begin
			res = {ns, ms - mr};
		end else begin
			res = {nr, mr - ms};
		end
		return res;
	endfunction

	// Valid bits for the five stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: sign and magnitude of both inputs.
	always_ff @(posedge clk) begin
		neg_s_s1 <= fwd_speed[DATA_W-1];
		neg_r_s1 <= turn_rate[DATA_W-1];
		abs_s_s1 <= fwd_speed[DATA_W-1] ? (~fwd_speed + 32'sd1) : fwd_speed;
		abs_r_s1 <= turn_rate[DATA_W-1] ? (~turn_rate + 32'sd1) : turn_rate;
	end

	// Stage 2: scale speed by twice one, and turn rate by the track width.
	assign prod_r = abs_r_s1 * cfg.track_width;

	always_ff @(posedge clk) begin
		mag_s_s2 <= {{(31-FRAC_BITS){1'b0}}, abs_s_s1, {(FRAC_BITS+1){1'b0}}};
		mag_r_s2 <= prod_r;
		neg_s_s2 <= neg_s_s1;
		neg_r_s2 <= neg_r_s1;
	end

	// Stage 3: left is speed minus the turn term, right is speed plus it.
	assign mix_l = lane_mix(mag_s_s2, neg_s_s2, mag_r_s2, ~neg_r_s2);
	assign mix_r = lane_mix(mag_s_s2, neg_s_s2, mag_r_s2, neg_r_s2);

	always_ff @(posedge clk) begin
		mag_l_s3 <= mix_l[63:0];
		neg_l_s3 <= mix_l[64];
		mag_r_s3 <= mix_r[63:0];
		neg_r_s3 <= mix_r[64];
	end

	// Stage 4: two 32x32 partial products per wheel against counts per unit.
	always_ff @(posedge clk) begin
		pp_lo_l_s4 <= mag_l_s3[31:0]  * cfg.counts_per_unit;
		pp_hi_l_s4 <= mag_l_s3[63:32] * cfg.counts_per_unit;
		pp_lo_r_s4 <= mag_r_s3[31:0]  * cfg.counts_per_unit;
		pp_hi_r_s4 <= mag_r_s3[63:32] * cfg.counts_per_unit;
		neg_l_s4   <= neg_l_s3;
		neg_r_s4   <= neg_r_s3;
	end

	// Stage 5: join partial products, round half away from zero, and keep a
	// nonzero product from rounding to zero.
	assign sum_l = {1'b0, pp_hi_l_s4, 32'b0} + {33'b0, pp_lo_l_s4} + RND;
	assign sum_r = {1'b0, pp_hi_r_s4, 32'b0} + {33'b0, pp_lo_r_s4} + RND;
	assign qraw_l = sum_l[96:SH];
	assign qraw_r = sum_r[96:SH];
	assign nz_l = |{pp_hi_l_s4, pp_lo_l_s4};
	assign nz_r = |{pp_hi_r_s4, pp_lo_r_s4};
	assign qfix_l = (qraw_l == '0 && nz_l) ? Q_W'(1) : qraw_l;
	assign qfix_r = (qraw_r == '0 && nz_r) ? Q_W'(1) : qraw_r;

	always_ff @(posedge clk) begin
		q_l_s5   <= qfix_l;
		q_r_s5   <= qfix_r;
		neg_l_s5 <= neg_l_s4 && nz_l;
		neg_r_s5 <= neg_r_s4 && nz_r;
	end

	assign ctl.valid = v_s5;
	assign ctl.neg_l = neg_l_s5;
	assign ctl.neg_r = neg_r_s5;
	assign ctl.over  = 1'b0;
	assign q_l = q_l_s5;
	assign q_r = q_r_s5;

endmodule

/* rtl/ddwr_div_stage.sv */
// One restoring division step for both wheels, with its pipeline register.
// Depends on ddwr_pkg for ctl_t and LIM_W.
module ddwr_div_stage import ddwr_pkg::*; #(
	parameter int Q_W = 96 - 3*FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl_in,
	input  logic [Q_W-1:0]   den_in,
	input  logic [Q_W-1:0]   rem_l_in,
	input  logic [Q_W-1:0]   rem_r_in,
	input  logic [LIM_W-1:0] sq_l_in,
	input  logic [LIM_W-1:0] sq_r_in,
	output ctl_t             ctl_out,
	output logic [Q_W-1:0]   den_out,
	output logic [Q_W-1:0]   rem_l_out,
	output logic [Q_W-1:0]   rem_r_out,
	output logic [LIM_W-1:0] sq_l_out,
	output logic [LIM_W-1:0] sq_r_out
);

	ctl_t             ctl_s1;
	logic [Q_W-1:0]   den_s1, rem_l_s1, rem_r_s1;
	logic [LIM_W-1:0] sq_l_s1, sq_r_s1;
	logic [Q_W:0]     step_l, step_r;

	// Shift in the next dividend bit and subtract when the divisor fits.
	// Returns {quotient bit, new remainder}.
	function automatic logic [Q_W:0] div_step(input logic [Q_W-1:0] rem,
			input logic nbit, input logic [Q_W-1:0] den);
		logic [Q_W:0] trial;
		logic [Q_W:0] diff;
		logic         ge;
		trial = {rem, nbit};
		diff  = trial - {1'b0, den};
		ge    = (trial >= {1'b0, den});
		return ge ? {1'b1, diff[Q_W-1:0]} : {1'b0, trial[Q_W-1:0]};
	endfunction

	assign step_l = div_step(rem_l_in, sq_l_in[LIM_W-1], den_in);
	assign step_r = div_step(rem_r_in, sq_r_in[LIM_W-1], den_in);

	// Control travels with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	// Remainder, and dividend bits shifting out as quotient bits shift in.
	always_ff @(posedge clk) begin
		den_s1   <= den_in;
		rem_l_s1 <= step_l[Q_W-1:0];
		rem_r_s1 <= step_r[Q_W-1:0];
		sq_l_s1  <= {sq_l_in[LIM_W-2:0], step_l[Q_W]};
		sq_r_s1  <= {sq_r_in[LIM_W-2:0], step_r[Q_W]};
	end

	assign ctl_out   = ctl_s1;
	assign den_out   = den_s1;
	assign rem_l_out = rem_l_s1;
	assign rem_r_out = rem_r_s1;
	assign sq_l_out  = sq_l_s1;
	assign sq_r_out  = sq_r_s1;

endmodule

/* rtl/ddwr_scale.sv */
// Encoder limit scaling: limit check, dividend products, a pipelined divider
// chain and the signed result register. Depends on ddwr_pkg and ddwr_div_stage.
module ddwr_scale import ddwr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctl_t                      ctl_in,
	input  logic [96-3*FRAC_BITS-1:0] q_l,
	input  logic [96-3*FRAC_BITS-1:0] q_r,
	input  logic [LIM_W-1:0]          encoder_limit,
	output logic                      done,
	output logic signed [OUT_W-1:0]   left_counts,
	output logic signed [OUT_W-1:0]   right_counts,
	output logic                      was_limited
);

	localparam int Q_W   = 96 - 3*FRAC_BITS;
	localparam int NCH   = (Q_W + 31) / 32;
	localparam int EXT_W = NCH*32;
	localparam int SUM_W = EXT_W + LIM_W;
	localparam int N_W   = Q_W + LIM_W;

	// Stage 6: limit check and choice of divisor and multiplier.
	ctl_t             ctl_s6;
	logic [Q_W-1:0]   q_l_s6, q_r_s6, den_s6;
	logic [LIM_W-1:0] mul_s6;
	logic             over;
	logic [Q_W-1:0]   big;

	// Stage 7: partial products of magnitude times multiplier.
	ctl_t             ctl_s7;
	logic [Q_W-1:0]   den_s7;
	logic [31+LIM_W:0] pp_l_s7 [NCH];
	logic [31+LIM_W:0] pp_r_s7 [NCH];
	logic [EXT_W-1:0] ext_l, ext_r;

	// Stage 8: dividend split into starting remainder and remaining bits.
	ctl_t             ctl_s8;
	logic [Q_W-1:0]   den_s8, rem_l_s8, rem_r_s8;
	logic [LIM_W-1:0] sq_l_s8, sq_r_s8;
	logic [SUM_W-1:0] n_l, n_r;

	// Divider chain, one quotient bit per stage.
	ctl_t             ctl_d   [LIM_W+1];
	logic [Q_W-1:0]   den_d   [LIM_W+1];
	logic [Q_W-1:0]   rem_l_d [LIM_W+1];
	logic [Q_W-1:0]   rem_r_d [LIM_W+1];
	logic [LIM_W-1:0] sq_l_d  [LIM_W+1];
	logic [LIM_W-1:0] sq_r_d  [LIM_W+1];

	// Result register.
	logic                    done_q, was_limited_q;
	logic signed [OUT_W-1:0] left_q, right_q;
	logic [LIM_W-1:0]        quo_l, quo_r;
	logic                    neg_l, neg_r;

	// Limit test. Without limiting, a divisor and multiplier of one pass the
	// magnitude through the divider unchanged.
	assign over = (q_l > Q_W'(encoder_limit)) || (q_r > Q_W'(encoder_limit));
	assign big  = (q_l >= q_r) ? q_l : q_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else begin
			ctl_s6.valid <= ctl_in.valid;
			ctl_s6.neg_l <= ctl_in.neg_l;
			ctl_s6.neg_r <= ctl_in.neg_r;
			ctl_s6.over  <= over;
			ctl_s7       <= ctl_s6;
			ctl_s8       <= ctl_s7;
		end
	end

	always_ff @(posedge clk) begin
		q_l_s6 <= q_l;
		q_r_s6 <= q_r;
		den_s6 <= over ? big : Q_W'(1);
		mul_s6 <= over ? encoder_limit : LIM_W'(1);
	end

	// Magnitudes cut into 32-bit chunks, each multiplied on its own.
	assign ext_l = EXT_W'(q_l_s6);
	assign ext_r = EXT_W'(q_r_s6);

	always_ff @(posedge clk) begin
		den_s7 <= den_s6;
		for (int k = 0; k < NCH; k++) begin
			pp_l_s7[k] <= ext_l[32*k +: 32] * mul_s6;
			pp_r_s7[k] <= ext_r[32*k +: 32] * mul_s6;
		end
	end

	// Sum of the shifted partial products gives the full dividend.
	always_comb begin
		n_l = '0;
		n_r = '0;
		for (int k = 0; k < NCH; k++) begin
			n_l = n_l + (SUM_W'(pp_l_s7[k]) << (32*k));
			n_r = n_r + (SUM_W'(pp_r_s7[k]) << (32*k));
		end
	end

	// The quotient fits the limit width, so the upper dividend bits are
	// already below the divisor and serve as the first remainder.
	always_ff @(posedge clk) begin
		den_s8   <= den_s7;
		rem_l_s8 <= n_l[N_W-1:LIM_W];
		rem_r_s8 <= n_r[N_W-1:LIM_W];
		sq_l_s8  <= n_l[LIM_W-1:0];
		sq_r_s8  <= n_r[LIM_W-1:0];
	end

	assign ctl_d[0]   = ctl_s8;
	assign den_d[0]   = den_s8;
	assign rem_l_d[0] = rem_l_s8;
	assign rem_r_d[0] = rem_r_s8;
	assign sq_l_d[0]  = sq_l_s8;
	assign sq_r_d[0]  = sq_r_s8;

	for (genvar i = 0; i < LIM_W; i++) begin : g_div
		ddwr_div_stage #(
			.Q_W(Q_W)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl_d[i]),
			.den_in   (den_d[i]),
			.rem_l_in (rem_l_d[i]),
			.rem_r_in (rem_r_d[i]),
			.sq_l_in  (sq_l_d[i]),
			.sq_r_in  (sq_r_d[i]),
			.ctl_out  (ctl_d[i+1]),
			.den_out  (den_d[i+1]),
			.rem_l_out(rem_l_d[i+1]),
			.rem_r_out(rem_r_d[i+1]),
			.sq_l_out (sq_l_d[i+1]),
			.sq_r_out (sq_r_d[i+1])
		);
	end

	// Apply signs; a wheel scaled to zero loses its sign.
	assign quo_l = sq_l_d[LIM_W];
	assign quo_r = sq_r_d[LIM_W];
	assign neg_l = ctl_d[LIM_W].neg_l && (quo_l != '0);
	assign neg_r = ctl_d[LIM_W].neg_r && (quo_r != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_d[LIM_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		left_q        <= neg_l ? -$signed({1'b0, quo_l}) : $signed({1'b0, quo_l});
		right_q       <= neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
		was_limited_q <= ctl_d[LIM_W].over;
	end

	assign done         = done_q;
	assign left_counts  = left_q;
	assign right_counts = right_q;
	assign was_limited  = was_limited_q;

endmodule

/* rtl/diff_drive_wheel_count_rates.sv */
// Top level of the differential-drive wheel rate block.
// Depends on ddwr_pkg, ddwr_cfg, ddwr_kin and ddwr_scale.
//
// Channel   Ports                                          Transfer
// command   start, busy, fwd_speed, turn_rate              start high, busy low
// config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid and cfg_ready
// result    done, left_counts, right_counts, was_limited   done high, one cycle
//
// A command may be issued every cycle; busy stays low. Each result passes
// through five kinematics stages, three limit and product stages, one
// divider stage per quotient bit (24) and the result register. Results
// leave in command order and the receiver cannot stall them. Reset clears
// the pipeline valid bits and loads the register defaults.
module diff_drive_wheel_count_rates import ddwr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] fwd_speed,
	input  logic signed [DATA_W-1:0] turn_rate,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	output logic                     done,
	output logic signed [OUT_W-1:0]  left_counts,
	output logic signed [OUT_W-1:0]  right_counts,
	output logic                     was_limited
);

	localparam int Q_W = 96 - 3*FRAC_BITS;

	cfg_t           cfg;
	ctl_t           kin_ctl;
	logic [Q_W-1:0] kin_q_l, kin_q_r;
	logic           cmd_valid;

	// The pipeline never stalls, so a command is always taken.
	assign busy      = 1'b0;
	assign cmd_valid = start && !busy;

	ddwr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	ddwr_kin #(
		.FRAC_BITS(FRAC_BITS)
	) u_kin (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_valid),
		.fwd_speed(fwd_speed),
		.turn_rate(turn_rate),
		.cfg      (cfg),
		.ctl      (kin_ctl),
		.q_l      (kin_q_l),
		.q_r      (kin_q_r)
	);

	ddwr_scale #(
		.FRAC_BITS(FRAC_BITS)
	) u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_in       (kin_ctl),
		.q_l          (kin_q_l),
		.q_r          (kin_q_r),
		.encoder_limit(cfg.encoder_limit),
		.done         (done),
		.left_counts  (left_counts),
		.right_counts (right_counts),
		.was_limited  (was_limited)
	);

endmodule
